// File: hdl/lzw_pkg.sv
package lzw_pkg;

  localparam int unsigned DictEntries = 4096;
  localparam int unsigned CodeW = 12;
  localparam int unsigned Slots = 4096;
  localparam int unsigned SlotW = 12;
  localparam int unsigned QueueDepth = 2;
  localparam logic [CodeW-1:0] EndCode = 12'h100;
  localparam logic [CodeW:0] FirstCode = 13'h101;
  localparam logic [CodeW:0] DictLimit = 13'(DictEntries);

  localparam logic KindData = 1'b0;
  localparam logic KindEnd = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_word;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StProbeRead,
    StProbeWait,
    StProbeCheck,
    StEntryWait,
    StEntryCheck,
    StInsert,
    StEmitPrefix,
    StEmitEnd,
    StClear
  } be_state_e;

endpackage

// File: hdl/lzw_if.sv
interface lzw_in_if;
  logic                  valid;
  logic                  ready;
  lzw_pkg::in_item_t     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lzw_out_if;
  logic                  valid;
  logic                  ready;
  lzw_pkg::out_item_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/lzw_ram.sv
module lzw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: hdl/lzw_front.sv
// Input queue: takes transactions and hands them to the back end in order.
module lzw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  lzw_in_if.sink              in_i,
  output logic                item_valid_o,
  output lzw_pkg::in_item_t   item_o,
  input  logic                item_pop_i
);
  lzw_pkg::in_item_t buf_q [lzw_pkg::QueueDepth];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_i.ready   = (cnt_q != 2'(lzw_pkg::QueueDepth));
  assign push         = in_i.valid && in_i.ready;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = buf_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q + 1'(push);
    rptr_d = rptr_q + 1'(item_pop_i);
    cnt_d  = cnt_q + 2'(push) - 2'(item_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= in_i.payload;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_i |-> item_valid_o) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(lzw_pkg::QueueDepth)) else $error("queue count overflow");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !item_pop_i) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count lost a push");
endmodule

// File: hdl/lzw_back.sv
// Dictionary engine: hash probe, insert, emit and table clear.
module lzw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  lzw_pkg::in_item_t   item_i,
  output logic                item_pop_o,
  lzw_out_if.source           out_o
);
  localparam int unsigned SW = lzw_pkg::SlotW;
  localparam int unsigned CW = lzw_pkg::CodeW;

  lzw_pkg::be_state_e state_q, state_d;
  logic [CW:0]   next_q, next_d;
  logic [CW-1:0] prefix_q, prefix_d;
  logic          pvalid_q, pvalid_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [7:0]    byte_q, byte_d;
  logic          kind_q, kind_d;
  logic [CW-1:0] code_q, code_d;
  logic          oval_q, oval_d;
  lzw_pkg::out_item_t opay_q, opay_d;

  logic          slot_we, ent_we;
  logic [SW-1:0] slot_waddr, slot_raddr;
  logic [CW-1:0] slot_wdata, slot_rdata;
  logic [CW-1:0] ent_raddr;
  logic [CW+7:0] ent_rdata;
  logic          out_free, full;

  lzw_ram #(.Width(CW), .Depth(lzw_pkg::Slots)) u_slot (
    .clk_i, .we_i(slot_we), .waddr_i(slot_waddr), .wdata_i(slot_wdata),
    .raddr_i(slot_raddr), .rdata_o(slot_rdata));

  lzw_ram #(.Width(CW + 8), .Depth(lzw_pkg::DictEntries)) u_entry (
    .clk_i, .we_i(ent_we), .waddr_i(next_q[$clog2(lzw_pkg::DictEntries)-1:0]),
    .wdata_i({prefix_q, byte_q}),
    .raddr_i(ent_raddr[$clog2(lzw_pkg::DictEntries)-1:0]),
    .rdata_o(ent_rdata));

  assign out_free     = !oval_q || out_o.ready;
  assign out_o.valid  = oval_q;
  assign out_o.payload = opay_q;
  assign full         = (next_q >= lzw_pkg::DictLimit);
  assign slot_raddr   = slot_q;
  assign ent_raddr    = code_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lzw_pkg::StIdle: begin
        if (item_valid_i) begin
          if (item_i.kind == lzw_pkg::KindEnd) begin
            state_d = pvalid_q ? lzw_pkg::StEmitPrefix : lzw_pkg::StEmitEnd;
          end else if (pvalid_q) begin
            state_d = lzw_pkg::StProbeWait;
          end
        end
      end
      lzw_pkg::StProbeRead:  state_d = lzw_pkg::StProbeWait;
      lzw_pkg::StProbeWait:  state_d = lzw_pkg::StProbeCheck;
      lzw_pkg::StProbeCheck: begin
        state_d = (slot_rdata == '0) ? lzw_pkg::StEmitPrefix : lzw_pkg::StEntryWait;
      end
      lzw_pkg::StEntryWait:  state_d = lzw_pkg::StEntryCheck;
      lzw_pkg::StEntryCheck: begin
        if (ent_rdata == {prefix_q, byte_q}) begin
          state_d = lzw_pkg::StIdle;
        end else begin
          state_d = lzw_pkg::StProbeRead;
        end
      end
      lzw_pkg::StEmitPrefix: begin
        if (out_free) begin
          if (kind_q == lzw_pkg::KindEnd) state_d = lzw_pkg::StEmitEnd;
          else if (full) state_d = lzw_pkg::StIdle;
          else state_d = lzw_pkg::StInsert;
        end
      end
      lzw_pkg::StInsert:     state_d = lzw_pkg::StIdle;
      lzw_pkg::StEmitEnd:    if (out_free) state_d = lzw_pkg::StClear;
      lzw_pkg::StClear:      if (slot_q == '1) state_d = lzw_pkg::StIdle;
      default:               state_d = lzw_pkg::StIdle;
    endcase
  end

  always_comb begin
    next_d     = next_q;
    prefix_d   = prefix_q;
    pvalid_d   = pvalid_q;
    slot_d     = slot_q;
    byte_d     = byte_q;
    kind_d     = kind_q;
    code_d     = code_q;
    oval_d     = oval_q && !out_o.ready;
    opay_d     = opay_q;
    item_pop_o = 1'b0;
    slot_we    = 1'b0;
    slot_waddr = slot_q;
    slot_wdata = next_q[CW-1:0];
    ent_we     = 1'b0;
    case (state_q)
      lzw_pkg::StIdle: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          kind_d = item_i.kind;
          byte_d = item_i.data_byte;
          slot_d = prefix_q ^ SW'(item_i.data_byte);
          if (item_i.kind == lzw_pkg::KindData && !pvalid_q) begin
            prefix_d = CW'(item_i.data_byte);
            pvalid_d = 1'b1;
          end
        end
      end
      lzw_pkg::StProbeCheck: begin
        code_d = slot_rdata;
      end
      lzw_pkg::StEntryCheck: begin
        if (ent_rdata == {prefix_q, byte_q}) prefix_d = code_q;
        else slot_d = slot_q + 1'b1;
      end
      lzw_pkg::StEmitPrefix: begin
        if (out_free) begin
          oval_d = 1'b1;
          opay_d = '{code_word: {prefix_q, 4'h0}, last: 1'b0};
          if (kind_q == lzw_pkg::KindData) begin
            if (!full) ent_we = 1'b1;
            else prefix_d = CW'(byte_q);
          end
        end
      end
      lzw_pkg::StInsert: begin
        slot_we  = 1'b1;
        next_d   = next_q + 1'b1;
        prefix_d = CW'(byte_q);
      end
      lzw_pkg::StEmitEnd: begin
        if (out_free) begin
          oval_d = 1'b1;
          opay_d = '{code_word: {lzw_pkg::EndCode, 4'h0}, last: 1'b1};
          slot_d = '0;
        end
      end
      lzw_pkg::StClear: begin
        slot_we    = 1'b1;
        slot_wdata = '0;
        slot_d     = slot_q + 1'b1;
        next_d     = lzw_pkg::FirstCode;
        prefix_d   = '0;
        pvalid_d   = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lzw_pkg::StClear;
      next_q   <= lzw_pkg::FirstCode;
      prefix_q <= '0;
      pvalid_q <= 1'b0;
      slot_q   <= '0;
      oval_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      next_q   <= next_d;
      prefix_q <= prefix_d;
      pvalid_q <= pvalid_d;
      slot_q   <= slot_d;
      oval_q   <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    kind_q <= kind_d;
    code_q <= code_d;
    opay_q <= opay_d;
  end

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> state_q == lzw_pkg::StIdle) else $error("pop outside idle");
  a_next_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= lzw_pkg::DictLimit) else $error("next code overran dictionary");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oval_q && !out_o.ready) |=> oval_q && $stable(opay_q))
    else $error("stalled result changed");
  a_ins_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_we |-> !full) else $error("insert into full dictionary");
endmodule

// File: hdl/lzw_12bit_encoder_core.sv
// Fixed 12-bit LZW encoder. A byte that extends the prefix passes the
// probe wait, probe check, entry wait and entry check states when the
// first hash probe hits, plus probe read and those four per further probe
// on the linear chain, as the hash slot and dictionary memories have
// registered reads. A byte that closes the prefix probes up to the empty
// slot, emits and, unless the dictionary is full, inserts; emitting waits
// while the result register is still held. The first byte of a stream
// only loads the prefix. After reset and each end of stream, a clearing
// pass empties the hash table; input is only queued (two deep) meanwhile.
module lzw_12bit_encoder_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  lzw_in_if.sink   in_i,
  lzw_out_if.source out_o
);
  logic              item_valid, item_pop;
  lzw_pkg::in_item_t item;

  lzw_front u_front (
    .clk_i, .rst_ni, .in_i,
    .item_valid_o(item_valid), .item_o(item), .item_pop_i(item_pop));

  lzw_back u_back (
    .clk_i, .rst_ni,
    .item_valid_i(item_valid), .item_i(item), .item_pop_o(item_pop), .out_o);
endmodule

// File: test/tb_lzw_12bit_encoder_core.sv
module tb_lzw_12bit_encoder_core;

  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned DrainCycles = 64;

  // Tracks the encoder's dictionary and pending prefix, and holds the code
  // words that the accepted bytes are due to produce.
  class lzw_scoreboard;
    lzw_pkg::out_item_t code_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned full_hits;
    bit [11:0]   parent_mem[lzw_pkg::Slots];
    bit [7:0]    byte_mem[lzw_pkg::Slots];
    bit [11:0]   slot_mem[lzw_pkg::Slots];
    bit [12:0]   next_code;
    bit [11:0]   prefix;
    bit          prefix_ok;

    function new();
      clear_dict();
      errors = 0;
      checked = 0;
      full_hits = 0;
    endfunction

    function void clear_dict();
      foreach (slot_mem[i]) begin
        slot_mem[i] = '0;
        parent_mem[i] = '0;
        byte_mem[i] = '0;
      end
      next_code = lzw_pkg::FirstCode;
      prefix = '0;
      prefix_ok = 1'b0;
    endfunction

    function bit [11:0] find_code(bit [11:0] parent, bit [7:0] b);
      bit [11:0] h;
      bit [11:0] c;
      h = parent ^ {4'h0, b};
      for (int n = 0; n < lzw_pkg::Slots; n++) begin
        c = slot_mem[h];
        if (c == 0) return '0;
        if (parent_mem[c] == parent && byte_mem[c] == b) return c;
        h = h + 12'd1;
      end
      return '0;
    endfunction

    function void add_string(bit [11:0] parent, bit [7:0] b);
      bit [11:0] h;
      if (next_code >= lzw_pkg::DictLimit) begin
        full_hits++;
        return;
      end
      parent_mem[next_code[11:0]] = parent;
      byte_mem[next_code[11:0]] = b;
      h = parent ^ {4'h0, b};
      for (int n = 0; n < lzw_pkg::Slots; n++) begin
        if (slot_mem[h] == 0) begin
          slot_mem[h] = next_code[11:0];
          break;
        end
        h = h + 12'd1;
      end
      next_code = next_code + 13'd1;
    endfunction

    function void push_code(bit [11:0] code, bit last);
      lzw_pkg::out_item_t o;
      o.code_word = {code, 4'h0};
      o.last = last;
      code_q.push_back(o);
    endfunction

    function void note_input(lzw_pkg::in_item_t it);
      bit [11:0] c;
      if (it.kind == lzw_pkg::KindEnd) begin
        if (prefix_ok) push_code(prefix, 1'b0);
        push_code(lzw_pkg::EndCode, 1'b1);
        clear_dict();
        return;
      end
      if (!prefix_ok) begin
        prefix = {4'h0, it.data_byte};
        prefix_ok = 1'b1;
        return;
      end
      c = find_code(prefix, it.data_byte);
      if (c != 0) begin
        prefix = c;
        return;
      end
      push_code(prefix, 1'b0);
      add_string(prefix, it.data_byte);
      prefix = {4'h0, it.data_byte};
    endfunction

    function void check_result(lzw_pkg::out_item_t got);
      lzw_pkg::out_item_t want;
      checked++;
      if (code_q.size() == 0) begin
        $error("unexpected code word %h last %b", got.code_word, got.last);
        errors++;
        return;
      end
      want = code_q.pop_front();
      if (got.code_word !== want.code_word) begin
        $error("code_word: expected %h, actual %h", want.code_word, got.code_word);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, actual %b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  lzw_in_if  in_bus();
  lzw_out_if out_bus();

  lzw_12bit_encoder_core u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  lzw_scoreboard sb = new();
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_cycles;
  int unsigned cycle_cnt;
  int unsigned stream_cnt;
  int unsigned byte_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d code words outstanding",
               cycle_cnt, sb.code_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off that it counts down itself.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        out_bus.ready = 1'b0;
      end else begin
        out_bus.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) sb.check_result(out_bus.payload);
  end

  task automatic send_item(input logic kind, input logic [7:0] b);
    lzw_pkg::in_item_t it;
    it.kind = kind;
    it.data_byte = b;
    if ($urandom_range(99) < idle_pct) begin
      in_bus.valid = 1'b0;
      while ($urandom_range(99) < idle_pct) @(negedge clk);
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.payload = it;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_input(it);
    if (kind == lzw_pkg::KindEnd) stream_cnt++;
    else byte_cnt++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_bus.valid = 1'b0;
    while (sb.code_q.size() != 0) @(negedge clk);
  endtask

  // One stream: mode 0 draws any byte, mode 1 a few nearby bytes so that
  // long prefixes build up, mode 2 runs of one byte.
  task automatic send_stream(input int unsigned len, input int unsigned mode);
    logic [7:0] base;
    logic [7:0] b;
    base = 8'($urandom_range(255));
    b = base;
    for (int unsigned i = 0; i < len; i++) begin
      case (mode)
        0: b = 8'($urandom_range(255));
        1: b = base + 8'($urandom_range(3));
        default: begin
          if ($urandom_range(7) == 0) b = 8'($urandom_range(255));
        end
      endcase
      send_item(lzw_pkg::KindData, b);
    end
    send_item(lzw_pkg::KindEnd, 8'($urandom_range(255)));
  endtask

  initial begin
    int unsigned phase;
    cycle_cnt = 0;
    stream_cnt = 0;
    byte_cnt = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    in_bus.valid = 1'b0;
    in_bus.payload = '0;
    rst_n = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty stream, single bytes at both extremes, a repeated byte
    // that walks the dictionary, and an end with a data byte of all ones.
    send_item(lzw_pkg::KindEnd, 8'h00);
    send_item(lzw_pkg::KindData, 8'h00);
    send_item(lzw_pkg::KindEnd, 8'hFF);
    send_item(lzw_pkg::KindData, 8'hFF);
    send_item(lzw_pkg::KindEnd, 8'h00);
    for (int i = 0; i < 10; i++) send_item(lzw_pkg::KindData, 8'h41);
    send_item(lzw_pkg::KindData, 8'h00);
    send_item(lzw_pkg::KindData, 8'hFF);
    send_item(lzw_pkg::KindData, 8'h41);
    send_item(lzw_pkg::KindData, 8'h41);
    send_item(lzw_pkg::KindEnd, 8'hFF);

    // Random streams across the idling phases.
    phase = 0;
    for (int s = 0; s < 20; s++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      phase = (phase + 1) % 4;
      if (s == 5) begin
        // Receiver holds off while bytes keep coming, filling the block.
        hold_cycles = 400;
        send_stream(120, 0);
      end else begin
        send_stream($urandom_range(150, 20), $urandom_range(2));
      end
      if (s % 6 == 3) wait_drained();
    end

    // A closing stream of random bytes under light receiver stalls.
    idle_pct = 0;
    stall_pct = 16;
    send_stream(80, 0);

    wait_drained();
    repeat (DrainCycles) @(negedge clk);

    $display("%0d streams, %0d bytes, %0d code words checked, %0d adds past full",
             stream_cnt, byte_cnt, sb.checked, sb.full_hits);
    if (sb.errors == 0 && sb.code_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/lzw_pkg.sv
hdl/lzw_if.sv
hdl/lzw_ram.sv
hdl/lzw_front.sv
hdl/lzw_back.sv
hdl/lzw_12bit_encoder_core.sv
test/tb_lzw_12bit_encoder_core.sv
